// File: src/sntp_client_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// sntp_client_sequencer_unit_macros
// Assertion helpers for the SNTP client sequencer.
// ----------------------------------------------------------------------------
`ifndef SNTP_CLIENT_SEQUENCER_UNIT_MACROS_SVH
`define SNTP_CLIENT_SEQUENCER_UNIT_MACROS_SVH

// Clocked implication check, held off during reset.
`define SCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sntp_cs_pkg.sv
// ----------------------------------------------------------------------------
// sntp_cs_pkg
// Shared types, constants and the request packet table of the SNTP client.
// ----------------------------------------------------------------------------
`default_nettype none

package sntp_cs_pkg;

  localparam int PACKET_BYTES = 48;
  localparam int POS_W        = $clog2(PACKET_BYTES);

  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

  typedef logic [1:0]       req_type_t;
  typedef logic [1:0]       cfg_idx_t;
  typedef logic [POS_W-1:0] pkt_pos_t;

  localparam req_type_t REQ_TICK    = 2'd0;
  localparam req_type_t REQ_RX_BYTE = 2'd1;
  localparam req_type_t REQ_START   = 2'd2;
  localparam req_type_t REQ_RESTART = 2'd3;

  localparam cfg_idx_t CFG_SYNC_INTERVAL = 2'd0;
  localparam cfg_idx_t CFG_MAX_WAIT      = 2'd1;
  localparam cfg_idx_t CFG_SERVER_COUNT  = 2'd2;

  localparam logic OUT_KIND_TX   = 1'b0;
  localparam logic OUT_KIND_TIME = 1'b1;

  function automatic logic [7:0] packet_byte(input pkt_pos_t pos);
    logic [7:0] b;
    unique case (int'(pos))
      0:       b = 8'hE3;
      2:       b = 8'd6;
      3:       b = 8'hEC;
      12:      b = 8'd49;
      13:      b = 8'h4E;
      14:      b = 8'd49;
      15:      b = 8'd52;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/sntp_cs_ifs.sv
// ----------------------------------------------------------------------------
// sntp_cs_ifs
// Valid/ready channels of the SNTP client: input items, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface sntp_cs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_seconds;
  logic [7:0]  rx_byte;
  logic        rx_last;

  modport source (output valid, req_type, now_seconds, rx_byte, rx_last, input ready);
  modport sink   (input valid, req_type, now_seconds, rx_byte, rx_last, output ready);
endinterface

interface sntp_cs_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [3:0]  server_index;
  logic [31:0] new_time;
  logic        run_last;

  modport source (output valid, out_kind, tx_byte, server_index, new_time, run_last,
                  input ready);
  modport sink   (input valid, out_kind, tx_byte, server_index, new_time, run_last,
                  output ready);
endinterface

interface sntp_cs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// File: src/sntp_client_sequencer_unit.sv
// The first result beat of an item passes the input register, then the result register.
// Throughput: one item per cycle for ticks, bytes and ignored items, unless the output stalls.
// A request run gives PACKET_BYTES (48) output beats from one run counter,
// one per cycle unless the output stalls, and holds the input register until it ends.
// Reset: mode idle, config at defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
// sntp_client_sequencer_unit
// SNTP client sequencer: request runs, retry/resync timing, reply capture.
// ----------------------------------------------------------------------------
`default_nettype none

module sntp_client_sequencer_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sntp_cs_in_if.sink   in_chan,
  sntp_cs_out_if.source out_chan,
  sntp_cs_cfg_if.sink  cfg_chan
);
  import sntp_cs_pkg::*;

  `include "sntp_client_sequencer_unit_macros.svh"

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  localparam logic [5:0] RX_POS_MAX  = 6'd63;
  localparam logic [5:0] STAMP_FIRST = 6'd40;
  localparam logic [5:0] STAMP_LAST  = 6'd43;
  localparam pkt_pos_t   POS_LAST    = POS_W'(PACKET_BYTES - 1);

  // config
  logic [31:0] sync_interval_r;
  logic [15:0] max_wait_r;
  logic [4:0]  server_count_r;

  // client state
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] request_time_r, request_time_nxt;
  logic [31:0] sync_time_r, sync_time_nxt;
  logic [3:0]  next_server_r, next_server_nxt;
  logic [5:0]  rx_pos_r, rx_pos_nxt;
  logic [31:0] stamp_r, stamp_nxt;

  // input register
  logic        in_valid_r, in_valid_nxt;
  req_type_t   in_type_r;
  logic [31:0] in_now_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // request run
  logic        run_active_r, run_active_nxt;
  pkt_pos_t    run_pos_r, run_pos_nxt;
  logic [3:0]  run_server_r, run_server_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  tx_byte_r, tx_byte_nxt;
  logic [3:0]  server_r, server_nxt;
  logic [31:0] new_time_r, new_time_nxt;
  logic        run_last_r, run_last_nxt;

  logic        slot_free, consume, tick_hit, send, byte_take;
  logic [4:0]  count_eff, server_inc;
  logic [31:0] stamp_upd;

  assign cfg_chan.ready = 1'b1;
  assign slot_free      = !out_valid_r || out_chan.ready;
  assign consume        = in_valid_r && !run_active_r && slot_free;
  assign in_chan.ready  = !in_valid_r || consume;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_kind     = out_kind_r;
  assign out_chan.tx_byte      = tx_byte_r;
  assign out_chan.server_index = server_r;
  assign out_chan.new_time     = new_time_r;
  assign out_chan.run_last     = run_last_r;

  always_comb begin
    tick_hit = 1'b0;
    if (in_type_r == REQ_TICK) begin
      if (mode_r == MODE_SYNC) begin
        tick_hit = (sync_time_r + sync_interval_r) < in_now_r;
      end else if (mode_r == MODE_WAIT) begin
        tick_hit = (request_time_r + 32'(max_wait_r)) < in_now_r;
      end
    end
  end

  assign send = consume && ((in_type_r == REQ_START) || tick_hit ||
                            (in_type_r == REQ_RESTART && mode_r == MODE_WAIT));
  assign byte_take = consume && (in_type_r == REQ_RX_BYTE) && (mode_r == MODE_WAIT);

  always_comb begin
    if (server_count_r == 5'd0) begin
      count_eff = 5'd1;
    end else if (server_count_r > 5'd16) begin
      count_eff = 5'd16;
    end else begin
      count_eff = server_count_r;
    end
    server_inc = {1'b0, next_server_r} + 5'd1;
  end

  always_comb begin
    stamp_upd = stamp_r;
    if (rx_pos_r >= STAMP_FIRST && rx_pos_r <= STAMP_LAST) begin
      unique case (rx_pos_r[1:0])
        2'd0: stamp_upd[31:24] = in_byte_r;
        2'd1: stamp_upd[23:16] = in_byte_r;
        2'd2: stamp_upd[15:8]  = in_byte_r;
        2'd3: stamp_upd[7:0]   = in_byte_r;
      endcase
    end
  end

  always_comb begin
    in_valid_nxt     = in_valid_r;
    mode_nxt         = mode_r;
    request_time_nxt = request_time_r;
    sync_time_nxt    = sync_time_r;
    next_server_nxt  = next_server_r;
    rx_pos_nxt       = rx_pos_r;
    stamp_nxt        = stamp_r;
    run_active_nxt   = run_active_r;
    run_pos_nxt      = run_pos_r;
    run_server_nxt   = run_server_r;
    out_valid_nxt    = out_valid_r;
    out_kind_nxt     = out_kind_r;
    tx_byte_nxt      = tx_byte_r;
    server_nxt       = server_r;
    new_time_nxt     = new_time_r;
    run_last_nxt     = run_last_r;

    if (in_chan.ready) begin
      in_valid_nxt = in_chan.valid;
    end

    if (slot_free) begin
      out_valid_nxt = 1'b0;
    end

    if (send) begin
      request_time_nxt = in_now_r;
      mode_nxt         = MODE_WAIT;
      stamp_nxt        = '0;
      rx_pos_nxt       = '0;
      next_server_nxt  = (server_inc >= count_eff) ? 4'd0 : server_inc[3:0];
      run_server_nxt   = next_server_r;
      run_pos_nxt      = POS_W'(1);
      run_active_nxt   = (POS_LAST != '0);
      out_valid_nxt    = 1'b1;
      out_kind_nxt     = OUT_KIND_TX;
      tx_byte_nxt      = packet_byte('0);
      server_nxt       = next_server_r;
      new_time_nxt     = '0;
      run_last_nxt     = (POS_LAST == '0);
    end else if (byte_take) begin
      stamp_nxt  = stamp_upd;
      rx_pos_nxt = (rx_pos_r < RX_POS_MAX) ? rx_pos_r + 6'd1 : rx_pos_r;
      if (in_last_r) begin
        sync_time_nxt = stamp_upd - NTP_UNIX_OFFSET;
        mode_nxt      = MODE_SYNC;
        rx_pos_nxt    = '0;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = OUT_KIND_TIME;
        tx_byte_nxt   = '0;
        server_nxt    = '0;
        new_time_nxt  = stamp_upd - NTP_UNIX_OFFSET;
        run_last_nxt  = 1'b1;
      end
    end else if (run_active_r && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = OUT_KIND_TX;
      tx_byte_nxt    = packet_byte(run_pos_r);
      server_nxt     = run_server_r;
      new_time_nxt   = '0;
      run_last_nxt   = (run_pos_r == POS_LAST);
      run_active_nxt = (run_pos_r != POS_LAST);
      run_pos_nxt    = run_pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_interval_r <= 32'd21600;
      max_wait_r      <= 16'd10;
      server_count_r  <= 5'd10;
      mode_r          <= MODE_IDLE;
      request_time_r  <= '0;
      sync_time_r     <= '0;
      next_server_r   <= '0;
      rx_pos_r        <= '0;
      stamp_r         <= '0;
      in_valid_r      <= 1'b0;
      run_active_r    <= 1'b0;
      run_pos_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.idx)
          CFG_SYNC_INTERVAL: sync_interval_r <= cfg_chan.wdata;
          CFG_MAX_WAIT:      max_wait_r      <= cfg_chan.wdata[15:0];
          CFG_SERVER_COUNT:  server_count_r  <= cfg_chan.wdata[4:0];
          default: ;
        endcase
      end
      mode_r         <= mode_nxt;
      request_time_r <= request_time_nxt;
      sync_time_r    <= sync_time_nxt;
      next_server_r  <= next_server_nxt;
      rx_pos_r       <= rx_pos_nxt;
      stamp_r        <= stamp_nxt;
      in_valid_r     <= in_valid_nxt;
      run_active_r   <= run_active_nxt;
      run_pos_r      <= run_pos_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      in_type_r <= in_chan.req_type;
      in_now_r  <= in_chan.now_seconds;
      in_byte_r <= in_chan.rx_byte;
      in_last_r <= in_chan.rx_last;
    end
    run_server_r <= run_server_nxt;
    out_kind_r   <= out_kind_nxt;
    tx_byte_r    <= tx_byte_nxt;
    server_r     <= server_nxt;
    new_time_r   <= new_time_nxt;
    run_last_r   <= run_last_nxt;
  end

  `SCS_ASSERT(a_no_consume_in_run, run_active_r |-> !consume, "item taken during run")
  `SCS_ASSERT(a_run_waits, run_active_r |-> (mode_r == MODE_WAIT), "run outside wait mode")
  `SCS_ASSERT(a_run_pos, run_active_r |-> (run_pos_r != '0), "run position zero")
  `SCS_ASSERT(a_time_last, (out_valid_r && out_kind_r == OUT_KIND_TIME) |-> run_last_r, "time update not last")

endmodule

`default_nettype wire
